// File: src/sorted_value_table_defines.svh
// Assertion macros used by svt_ctrl, the controller of the sorted value table RTL.
// Needs clock and reset signals of those names in the module that uses them.
`ifndef SORTED_VALUE_TABLE_DEFINES_SVH
`define SORTED_VALUE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define SVT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("svt assertion failed");
`define SVT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("svt assertion failed");
`else
`define SVT_ASSERT_IMPL(label, ante, cons)
`define SVT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/svt_pkg.sv
// Types and constants of the sorted value table.
// Used by the cell, the controller and the top level.
package svt_pkg;

   localparam int SVT_CAPACITY = 16;
   localparam int VALUE_W      = 32;
   localparam int COUNT_OUT_W  = 5;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD
   } state_type;

   typedef struct packed {
      logic [1:0]                command;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   found;
      logic [COUNT_OUT_W-1:0] entry_count;
   } rsp_type;

   // Per-phase commands broadcast from the controller to every cell.
   typedef struct packed {
      logic compare;
      logic insert_shift;
      logic delete_shift;
   } cell_ctl_type;

endpackage

// File: src/svt_cell.sv
// One table slot: holds an entry, compares it against the key and shifts
// toward a neighbor on insert or delete. Depends on svt_pkg.
module svt_cell
   import svt_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                      clock,
   input  cell_ctl_type              ctl,
   input  logic signed [VALUE_W-1:0] key,
   input  logic [CNT_W-1:0]          count,
   input  logic signed [VALUE_W-1:0] left_entry,
   input  logic                      left_lt,
   input  logic signed [VALUE_W-1:0] right_entry,
   output logic signed [VALUE_W-1:0] entry,
   output logic                      lt,
   output logic                      eq
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      lt_ff, lt_in;
   logic                      eq_ff, eq_in;
   logic                      occupied;

   assign occupied = count > CNT_W'(INDEX);

   always_comb begin
      entry_in = entry_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      if (ctl.compare) begin
         lt_in = occupied && (entry_ff < key);
         eq_in = occupied && (entry_ff == key);
      end
      // Entries below the insertion point stay; the slot at the point takes
      // the key and the ones above it move up by one.
      if (ctl.insert_shift && !lt_ff) begin
         entry_in = left_lt ? key : left_entry;
      end
      // The first equal entry sits right at the end of the smaller ones.
      if (ctl.delete_shift && !lt_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

// File: src/svt_ctrl.sv
// Command sequencer, entry count and result register of the sorted table.
// Depends on svt_pkg and sorted_value_table_defines.svh.
`include "sorted_value_table_defines.svh"
module svt_ctrl
   import svt_pkg::*;
#(
   parameter int CAPACITY = SVT_CAPACITY,
   parameter int CNT_W    = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_item,
   input  logic                      found,
   output cell_ctl_type              ctl,
   output logic signed [VALUE_W-1:0] key,
   output logic [CNT_W-1:0]          count,
   output logic                      rsp_strobe,
   output rsp_type                   rsp_item
);

   state_type                 state_ff, state_in;
   logic [1:0]                op_ff, op_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      full;
   logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

   assign full      = count_ff == CNT_W'(CAPACITY);
   assign count_ext = {{COUNT_OUT_W{1'b0}}, count_in};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctl          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_item.command;
               key_in   = req_item.value;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            ctl.compare = 1'b1;
            state_in    = ST_UPD;
         end
         ST_UPD: begin
            rsp_in.status = STATUS_DONE;
            if (op_ff == CMD_INSERT) begin
               if (full) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  ctl.insert_shift = 1'b1;
                  count_in         = count_ff + CNT_W'(1);
               end
            end else if (op_ff == CMD_DELETE) begin
               if (!found) begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end else begin
                  ctl.delete_shift = 1'b1;
                  count_in         = count_ff - CNT_W'(1);
               end
            end
            rsp_in.found       = found;
            rsp_in.entry_count = count_ext[COUNT_OUT_W-1:0];
            rsp_valid_in       = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign key        = key_ff;
   assign count      = count_ff;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   `SVT_ASSERT_NEXT(a_accept_to_cmp, start && !busy, state_ff == ST_CMP)
   `SVT_ASSERT_NEXT(a_upd_gives_rsp, state_ff == ST_UPD, rsp_valid_ff && state_ff == ST_IDLE)
   `SVT_ASSERT_NEXT(a_full_keeps_count, state_ff == ST_UPD && op_ff == CMD_INSERT && full,
      $stable(count_ff))
   `SVT_ASSERT_NEXT(a_miss_keeps_count, state_ff == ST_UPD && op_ff == CMD_DELETE && !found,
      $stable(count_ff))
   `SVT_ASSERT_IMPL(a_count_bound, state_ff != ST_UPD, count_ff <= CNT_W'(CAPACITY))

endmodule

// File: src/sorted_value_table.sv
// Sorted value table: one command per transfer, worked in a compare phase and a shift
// phase, then a registered result strobe.
// A new command is accepted only in idle. The compare phase sets each cell's less/equal
// flags; the shift phase moves the cell row on an insert or delete that is carried out.
// Synchronous reset empties the table and clears the sequencer; entries are not cleared.
// Depends on svt_pkg, svt_cell and svt_ctrl.
module sorted_value_table
   import svt_pkg::*;
#(
   parameter int CAPACITY = SVT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   cell_ctl_type              ctl;
   logic signed [VALUE_W-1:0] key;
   logic [CNT_W-1:0]          count;
   logic signed [VALUE_W-1:0] entries [CAPACITY];
   logic [CAPACITY-1:0]       lt_vec;
   logic [CAPACITY-1:0]       eq_vec;
   logic                      found;

   assign found = |eq_vec;

   svt_ctrl #(
      .CAPACITY(CAPACITY),
      .CNT_W   (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .found     (found),
      .ctl       (ctl),
      .key       (key),
      .count     (count),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_entry;
      logic                      left_lt;
      logic signed [VALUE_W-1:0] right_entry;

      if (g == 0) begin : g_first
         assign left_entry = key;
         assign left_lt    = 1'b1;
      end else begin : g_mid
         assign left_entry = entries[g-1];
         assign left_lt    = lt_vec[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_entry = entries[g];
      end else begin : g_inner
         assign right_entry = entries[g+1];
      end

      svt_cell #(
         .INDEX(g),
         .CNT_W(CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .key        (key),
         .count      (count),
         .left_entry (left_entry),
         .left_lt    (left_lt),
         .right_entry(right_entry),
         .entry      (entries[g]),
         .lt         (lt_vec[g]),
         .eq         (eq_vec[g])
      );
   end

endmodule

// File: verif/tb.sv
// Self-checking testbench for sorted_value_table: directed table, then random commands.
// Each accepted command is applied to a behavioral copy; each result is compared with its
// prediction or a typed row's result. Depends on svt_pkg and the sorted_value_table RTL.
`timescale 1ns / 1ps

module tb;
   import svt_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int DIRECTED_ROWS = 26;
   localparam int RANDOM_ITEMS = 1500;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 10;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } directed_row_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Behavioral copy of the table: ascending values, duplicates kept.
   logic signed [VALUE_W-1:0] table_values [SVT_CAPACITY];
   int table_count = 0;

   rsp_type pending_results [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   directed_row_type directed_rows [DIRECTED_ROWS];

   sorted_value_table #(.CAPACITY(SVT_CAPACITY)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one command to the table copy and returns the result it must give.
   function automatic rsp_type apply_command(input req_type item);
      rsp_type result;
      logic signed [VALUE_W-1:0] v;
      int below;
      int first_equal;
      v = item.value;
      below = 0;
      first_equal = -1;
      for (int i = 0; i < table_count; i++) begin
         if (table_values[i] < v)
            below++;
         if (table_values[i] == v && first_equal < 0)
            first_equal = i;
      end
      result.found = (first_equal >= 0);
      result.status = STATUS_DONE;
      if (item.command == CMD_INSERT) begin
         if (table_count >= SVT_CAPACITY) begin
            result.status = STATUS_FULL;
         end else begin
            for (int i = table_count; i > below; i--)
               table_values[i] = table_values[i - 1];
            table_values[below] = v;
            table_count++;
         end
      end else if (item.command == CMD_DELETE) begin
         if (first_equal < 0) begin
            result.status = STATUS_NOT_FOUND;
         end else begin
            for (int i = first_equal; i < table_count - 1; i++)
               table_values[i] = table_values[i + 1];
            table_count--;
         end
      end
      // Query and the unused code change nothing.
      result.entry_count = table_count[COUNT_OUT_W-1:0];
      return result;
   endfunction

   function automatic directed_row_type typed_row(input logic [1:0] command,
         input logic signed [VALUE_W-1:0] value, input logic [1:0] status,
         input logic found, input int count);
      directed_row_type row;
      row.req.command = command;
      row.req.value = value;
      row.typed = 1'b1;
      row.rsp.status = status;
      row.rsp.found = found;
      row.rsp.entry_count = count[COUNT_OUT_W-1:0];
      return row;
   endfunction

   function automatic directed_row_type predicted_row(input logic [1:0] command,
         input logic signed [VALUE_W-1:0] value);
      directed_row_type row;
      row.req.command = command;
      row.req.value = value;
      row.typed = 1'b0;
      row.rsp = '0;
      return row;
   endfunction

   // Called just after a falling edge; returns just after the falling edge that follows
   // the transfer. Start stays high across back-to-back commands.
   task automatic send_command(input req_type item, input bit typed, input rsp_type typed_rsp,
         input int gap);
      rsp_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      predicted = apply_command(item);
      pending_results.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   // Called just after a falling edge; start drops so that no command is taken twice.
   task automatic wait_for_results();
      start <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Values drawn mostly from a narrow range or from the table itself, so that
   // duplicates, hits on delete and hits on query are common.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      logic signed [VALUE_W-1:0] extreme_values [6];
      int r;
      extreme_values = '{VALUE_MIN, VALUE_MIN + 1, -1, 0, VALUE_MAX - 1, VALUE_MAX};
      r = $urandom_range(0, 99);
      if (r < 40)
         return $signed($urandom_range(0, 15)) - 8;
      if (r < 65 && table_count > 0)
         return table_values[$urandom_range(0, table_count - 1)];
      if (r < 75)
         return extreme_values[$urandom_range(0, 5)];
      return $urandom;
   endfunction

   task automatic check_field(input string name, input logic [7:0] expected,
         input logic [7:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                  actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type expected;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected, expected none, actual %p", $time,
                     rsp_item);
            mismatch_count++;
         end else begin
            expected = pending_results.pop_front();
            check_field("status", expected.status, rsp_item.status);
            check_field("found", expected.found, rsp_item.found);
            check_field("entry_count", expected.entry_count, rsp_item.entry_count);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      req_type item;
      int gap;
      int insert_bias;
      int r;
      bit no_idle;
      int bias_by_block [4];

      bias_by_block = '{85, 50, 15, 60};
      directed_rows = '{
         typed_row(CMD_QUERY, 0, STATUS_DONE, 1'b0, 0),
         typed_row(CMD_DELETE, 5, STATUS_NOT_FOUND, 1'b0, 0),
         typed_row(CMD_INSERT, VALUE_MAX, STATUS_DONE, 1'b0, 1),
         typed_row(CMD_INSERT, VALUE_MIN, STATUS_DONE, 1'b0, 2),
         typed_row(CMD_INSERT, 0, STATUS_DONE, 1'b0, 3),
         typed_row(CMD_INSERT, 0, STATUS_DONE, 1'b1, 4),
         typed_row(CMD_UNUSED, -1, STATUS_DONE, 1'b0, 4),
         typed_row(CMD_DELETE, 0, STATUS_DONE, 1'b1, 3),
         typed_row(CMD_DELETE, 7, STATUS_NOT_FOUND, 1'b0, 3),
         typed_row(CMD_QUERY, 0, STATUS_DONE, 1'b1, 3),
         predicted_row(CMD_INSERT, -5),
         predicted_row(CMD_INSERT, 100),
         predicted_row(CMD_INSERT, -100000),
         predicted_row(CMD_INSERT, VALUE_MAX - 1),
         predicted_row(CMD_INSERT, VALUE_MIN + 1),
         predicted_row(CMD_INSERT, 3),
         predicted_row(CMD_INSERT, 3),
         predicted_row(CMD_INSERT, 42),
         predicted_row(CMD_INSERT, -42),
         predicted_row(CMD_INSERT, 7),
         predicted_row(CMD_INSERT, 65536),
         predicted_row(CMD_INSERT, -65536),
         predicted_row(CMD_INSERT, 2),
         typed_row(CMD_INSERT, 1, STATUS_FULL, 1'b0, 16),
         typed_row(CMD_INSERT, VALUE_MAX, STATUS_FULL, 1'b1, 16),
         typed_row(CMD_DELETE, VALUE_MIN, STATUS_DONE, 1'b1, 15)
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_command(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp,
                      $urandom_range(0, 9));
      wait_for_results();
      @(negedge clock);

      // Blocks of 100 commands cycle through insert biases of 85, 50, 15 and 60 percent.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         insert_bias = bias_by_block[(n / 100) % 4];
         no_idle = ((n / 100) % 4 == 1);
         if (n % 500 == 250) begin
            wait_for_results();
            @(negedge clock);
         end
         r = $urandom_range(0, 99);
         if (r < insert_bias)
            item.command = CMD_INSERT;
         else if (r < insert_bias + 5)
            item.command = CMD_UNUSED;
         else if ($urandom_range(0, 2) != 0)
            item.command = CMD_DELETE;
         else
            item.command = CMD_QUERY;
         item.value = pick_value();
         gap = no_idle ? 0 : $urandom_range(0, 9);
         send_command(item, 1'b0, '0, gap);
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/svt_pkg.sv
src/svt_cell.sv
src/svt_ctrl.sv
src/sorted_value_table.sv
verif/tb.sv
